// File: hw/rtl/tli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_pkg
// Shared constants, item codes and command types of the table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W  = 2;
    localparam int IDX_W = 6;
    localparam int CFG_W = 7;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
    localparam logic [OP_W-1:0] OP_INV  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

    typedef struct packed {
        logic load;
        logic inv;
    } cmd_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/table_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Piecewise linear lookup between paired raw and score breakpoint tables.
//
// Input stream s_*: tuser carries op (load, raw to score, score to raw), tdata
// carries the index, load pair and query value. Loads write one pair and give
// no item; ops outside the three codes are dropped. Each query gives one item
// on m_* with the interpolated value.
// A load writes both tables when the engine takes it. A query runs a clamp to
// the first and last keys in use, forward and backward bracket scans at one
// entry a cycle over the table memory read port, a one-bit-per-cycle multiply
// of both terms, and a one-bit-per-cycle divider. Queries run one at a time.
// A two-item command queue sits in front, and an output register holds a
// finished item while m_tready is low; the engine waits with its next result
// until that register frees. Reset clears control state and sets
// entries_in_use to one; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEF,
    parameter int S_DW        = ((tli_pkg::IDX_W + 3 * VALUE_WIDTH + 7) / 8) * 8,
    parameter int M_DW        = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_we,
    input  wire  [tli_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    // entry_index, entry_raw, entry_score, query_value, zero pad
    input  wire  [S_DW-1:0]             s_tdata,
    // op
    input  wire  [tli_pkg::OP_W-1:0]    s_tuser,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    // result_value, zero pad
    output logic [M_DW-1:0]             m_tdata
);

    localparam int VW = VALUE_WIDTH;
    localparam int IW = tli_pkg::IDX_W;
    localparam int AW = $clog2(TABLE_DEPTH);

    logic [tli_pkg::CFG_W-1:0] cfg_reg;
    logic                      cmd_valid, cmd_ready;
    tli_pkg::cmd_ctl_t         cmd_ctl;
    logic [AW-1:0]             cmd_addr;
    logic [VW-1:0]             cmd_a, cmd_b;
    logic [VW-1:0]             res_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tli_pkg::CFG_RESET;
        end else if (cfg_we) begin
            cfg_reg <= cfg_wdata;
        end
    end

    tli_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VW),
        .AW          (AW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_index  (s_tdata[IW-1:0]),
        .in_raw    (s_tdata[IW+VW-1:IW]),
        .in_score  (s_tdata[IW+2*VW-1:IW+VW]),
        .in_query  (s_tdata[IW+3*VW-1:IW+2*VW]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_ctl   (cmd_ctl),
        .cmd_addr  (cmd_addr),
        .cmd_a     (cmd_a),
        .cmd_b     (cmd_b)
    );

    tli_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VW),
        .AW          (AW)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .entries_in_use (cfg_reg),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd_ctl        (cmd_ctl),
        .cmd_addr       (cmd_addr),
        .cmd_a          (cmd_a),
        .cmd_b          (cmd_b),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (res_data)
    );

    assign m_tdata = M_DW'(res_data);

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid set after reset");

    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (cfg_reg == $past(cfg_wdata)))
        else $error("configuration write lost");

    a_load_no_item: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready && cmd_ctl.load && !m_tvalid |=> !m_tvalid)
        else $error("load produced an item");

    a_busy_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid && cmd_ready && !cmd_ctl.load |=> !cmd_ready)
        else $error("engine took a command while running a query");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/tli_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_front
// Accepts items, classifies them as load, query or drop, and queues commands.
// ----------------------------------------------------------------------------
module tli_front #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [tli_pkg::OP_W-1:0]     in_op,
    input  wire  [tli_pkg::IDX_W-1:0]    in_index,
    input  wire  [VALUE_WIDTH-1:0]       in_raw,
    input  wire  [VALUE_WIDTH-1:0]       in_score,
    input  wire  [VALUE_WIDTH-1:0]       in_query,
    output logic                         cmd_valid,
    input  wire                          cmd_ready,
    output tli_pkg::cmd_ctl_t            cmd_ctl,
    output logic [AW-1:0]                cmd_addr,
    output logic [VALUE_WIDTH-1:0]       cmd_a,
    output logic [VALUE_WIDTH-1:0]       cmd_b
);

    tli_pkg::cmd_ctl_t      q_ctl_reg  [2];
    logic [AW-1:0]          q_addr_reg [2];
    logic [VALUE_WIDTH-1:0] q_a_reg    [2];
    logic [VALUE_WIDTH-1:0] q_b_reg    [2];
    logic                   wr_ptr_reg, wr_ptr_next;
    logic                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]             count_reg, count_next;

    logic                   keep;
    tli_pkg::cmd_ctl_t      ctl_in;
    logic [31:0]            idx_ext;
    logic                   push, pop;

    always_comb begin
        idx_ext     = 32'(in_index);
        ctl_in.load = (in_op == tli_pkg::OP_LOAD);
        ctl_in.inv  = (in_op == tli_pkg::OP_INV);
        keep        = ((in_op == tli_pkg::OP_LOAD) && (idx_ext < 32'(TABLE_DEPTH)))
                      || (in_op == tli_pkg::OP_FWD) || (in_op == tli_pkg::OP_INV);
    end

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;

    assign cmd_ctl  = q_ctl_reg[rd_ptr_reg];
    assign cmd_addr = q_addr_reg[rd_ptr_reg];
    assign cmd_a    = q_a_reg[rd_ptr_reg];
    assign cmd_b    = q_b_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_ctl_reg[wr_ptr_reg]  <= ctl_in;
            q_addr_reg[wr_ptr_reg] <= idx_ext[AW-1:0];
            q_a_reg[wr_ptr_reg]    <= ctl_in.load ? in_raw : in_query;
            q_b_reg[wr_ptr_reg]    <= in_score;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_div
// Restoring signed divider, one quotient bit a cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tli_div #(
    parameter int NW = 67,
    parameter int DW = 33
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  start,
    input  wire  signed [NW-1:0] num,
    input  wire  [DW-1:0]        den,
    output logic                 done,
    output logic [NW-1:0]        quo
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg;
    logic [NW-1:0] n_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [DW:0]   rem_sh;
    logic          ge;
    logic [DW:0]   rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, n_reg[NW-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= num[NW-1];
            n_reg   <= num[NW-1] ? (~num + 1'b1) : num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            n_reg   <= {n_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~n_reg + 1'b1) : n_reg;

endmodule
`default_nettype wire

// File: hw/rtl/tli_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tli_engine
// Table memories, clamp and bracket search, serial multiply, divide, output.
// ----------------------------------------------------------------------------
module tli_engine #(
    parameter int TABLE_DEPTH = tli_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = tli_pkg::VALUE_WIDTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [tli_pkg::CFG_W-1:0]    entries_in_use,
    input  wire                          cmd_valid,
    output logic                         cmd_ready,
    input  tli_pkg::cmd_ctl_t            cmd_ctl,
    input  wire  [AW-1:0]                cmd_addr,
    input  wire  [VALUE_WIDTH-1:0]       cmd_a,
    input  wire  [VALUE_WIDTH-1:0]       cmd_b,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [VALUE_WIDTH-1:0]       out_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int NW = 2 * VW + 3;
    localparam int MW = $clog2(VW);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_K0W  = 4'd1;
    localparam logic [3:0] S_KLW  = 4'd2;
    localparam logic [3:0] S_FW   = 4'd3;
    localparam logic [3:0] S_BW   = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DST  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [VW-1:0] raw_mem   [TABLE_DEPTH];
    logic [VW-1:0] score_mem [TABLE_DEPTH];
    logic [VW-1:0] raw_q_reg, score_q_reg;

    logic [3:0]           state_reg, state_next;
    logic                 inv_reg, inv_next;
    logic signed [VW-1:0] x_reg, x_next;
    logic signed [VW-1:0] ka_reg, ka_next, kb_reg, kb_next;
    logic signed [VW-1:0] va_reg, va_next, vb_reg, vb_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic signed [NW-1:0] acc_reg, acc_next;
    logic signed [NW-1:0] msh_reg, msh_next;
    logic [VW-1:0]        mb_reg, mb_next;
    logic [MW-1:0]        cnt_reg, cnt_next;
    logic                 ph_reg, ph_next;
    logic [VW-1:0]        res_reg, res_next;
    logic                 ov_reg, ov_next;
    logic [VW-1:0]        od_reg, od_next;

    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        last_idx;
    logic [31:0]          cfg_ext, cfg_m1;
    logic signed [VW-1:0] key, val;
    logic signed [VW:0]   d_kbx, d_xka, d_kbka;
    logic                 wr_en;
    logic                 div_start, div_done;
    logic [NW-1:0]        div_quo;

    always_comb begin
        cfg_ext = 32'(entries_in_use);
        cfg_m1  = cfg_ext - 32'd1;
        if (cfg_ext == 32'd0) begin
            last_idx = '0;
        end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
            last_idx = AW'(TABLE_DEPTH - 1);
        end else begin
            last_idx = cfg_m1[AW-1:0];
        end
    end

    assign key    = inv_reg ? score_q_reg : raw_q_reg;
    assign val    = inv_reg ? raw_q_reg : score_q_reg;
    assign d_kbx  = {kb_reg[VW-1], kb_reg} - {x_reg[VW-1], x_reg};
    assign d_xka  = {x_reg[VW-1], x_reg} - {ka_reg[VW-1], ka_reg};
    assign d_kbka = {kb_reg[VW-1], kb_reg} - {ka_reg[VW-1], ka_reg};

    assign cmd_ready = (state_reg == S_IDLE);
    assign wr_en     = cmd_valid && cmd_ready && cmd_ctl.load;
    assign div_start = (state_reg == S_DST);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            raw_mem[cmd_addr]   <= cmd_a;
            score_mem[cmd_addr] <= cmd_b;
        end
        raw_q_reg   <= raw_mem[rd_addr];
        score_q_reg <= score_mem[rd_addr];
    end

    tli_div #(
        .NW (NW),
        .DW (VW + 1)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc_reg),
        .den     (d_kbka),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        inv_next   = inv_reg;
        x_next     = x_reg;
        ka_next    = ka_reg;
        kb_next    = kb_reg;
        va_next    = va_reg;
        vb_next    = vb_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        msh_next   = msh_reg;
        mb_next    = mb_reg;
        cnt_next   = cnt_reg;
        ph_next    = ph_reg;
        res_next   = res_reg;
        ov_next    = (ov_reg && out_ready) ? 1'b0 : ov_reg;
        od_next    = od_reg;
        rd_addr    = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (cmd_valid && !cmd_ctl.load) begin
                    inv_next   = cmd_ctl.inv;
                    x_next     = cmd_a;
                    state_next = S_K0W;
                end
            end
            S_K0W: begin
                rd_addr = last_idx;
                if (x_reg < key) begin
                    x_next = key;
                end
                state_next = S_KLW;
            end
            S_KLW: begin
                rd_addr = '0;
                if (x_reg > key) begin
                    x_next  = key;
                    ka_next = key;
                    kb_next = key;
                    va_next = key;
                    vb_next = key;
                end else begin
                    ka_next = x_reg;
                    kb_next = x_reg;
                    va_next = x_reg;
                    vb_next = x_reg;
                end
                idx_next   = '0;
                state_next = S_FW;
            end
            S_FW: begin
                if (key >= x_reg || idx_reg == last_idx) begin
                    if (key >= x_reg) begin
                        kb_next = key;
                        vb_next = val;
                    end
                    rd_addr    = last_idx;
                    idx_next   = last_idx;
                    state_next = S_BW;
                end else begin
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_BW: begin
                rd_addr = idx_reg - 1'b1;
                if (key <= x_reg || idx_reg == '0) begin
                    if (key <= x_reg) begin
                        ka_next = key;
                        va_next = val;
                    end
                    state_next = S_CHK;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            S_CHK: begin
                if (ka_reg >= kb_reg) begin
                    res_next   = va_reg;
                    state_next = S_OUT;
                end else begin
                    acc_next   = '0;
                    msh_next   = {{(NW-VW-1){d_kbx[VW]}}, d_kbx};
                    mb_next    = va_reg;
                    cnt_next   = '0;
                    ph_next    = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                if (mb_reg[0]) begin
                    acc_next = (cnt_reg == MW'(VW - 1)) ? acc_reg - msh_reg
                                                        : acc_reg + msh_reg;
                end
                msh_next = msh_reg <<< 1;
                mb_next  = mb_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MW'(VW - 1)) begin
                    cnt_next = '0;
                    if (!ph_reg) begin
                        ph_next  = 1'b1;
                        msh_next = {{(NW-VW-1){d_xka[VW]}}, d_xka};
                        mb_next  = vb_reg;
                    end else begin
                        state_next = S_DST;
                    end
                end
            end
            S_DST: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    res_next   = div_quo[VW-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!ov_reg || out_ready) begin
                    ov_next    = 1'b1;
                    od_next    = res_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        inv_reg <= inv_next;
        x_reg   <= x_next;
        ka_reg  <= ka_next;
        kb_reg  <= kb_next;
        va_reg  <= va_next;
        vb_reg  <= vb_next;
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        msh_reg <= msh_next;
        mb_reg  <= mb_next;
        cnt_reg <= cnt_next;
        ph_reg  <= ph_next;
        res_reg <= res_next;
        od_reg  <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule
`default_nettype wire

// File: tb/sv/table_interp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_interp_checker
// Watches the load/query and result channels of the table interpolator, keeps
// its own copy of the breakpoint tables and entry count, predicts each query
// result and compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module table_interp_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [103:0] s_tdata,
    input  wire  [1:0]  s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,
    output int          error_count,
    output int          pending_results,
    output int          results_checked
);

    logic [31:0] raw_tab [64];
    logic [31:0] score_tab [64];
    logic [6:0]  entries_cfg;
    logic [31:0] expected_values[$];

    function automatic logic [31:0] interpolate(input bit inv, input logic [31:0] value);
        longint x, ka, kb, va, vb, key0, keyl;
        int n;
        int i;
        logic signed [127:0] dka, dkb, wa, wb, den, quo;
        n = (entries_cfg == 0) ? 1 : ((entries_cfg > 64) ? 64 : int'(entries_cfg));
        x = longint'($signed(value));
        key0 = longint'($signed(inv ? score_tab[0] : raw_tab[0]));
        keyl = longint'($signed(inv ? score_tab[n-1] : raw_tab[n-1]));
        if (x < key0) x = key0;
        if (x > keyl) x = keyl;
        ka = x; kb = x; va = x; vb = x;
        for (i = 0; i < n; i++) begin
            if (x <= longint'($signed(inv ? score_tab[i] : raw_tab[i]))) begin
                kb = longint'($signed(inv ? score_tab[i] : raw_tab[i]));
                vb = longint'($signed(inv ? raw_tab[i] : score_tab[i]));
                break;
            end
        end
        for (i = n - 1; i >= 0; i--) begin
            if (x >= longint'($signed(inv ? score_tab[i] : raw_tab[i]))) begin
                ka = longint'($signed(inv ? score_tab[i] : raw_tab[i]));
                va = longint'($signed(inv ? raw_tab[i] : score_tab[i]));
                break;
            end
        end
        if (ka >= kb) return va[31:0];
        dkb = kb - x;
        dka = x - ka;
        wa = va;
        wb = vb;
        den = kb - ka;
        quo = (dkb * wa + dka * wb) / den;
        return quo[31:0];
    endfunction

    assign pending_results = expected_values.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            entries_cfg <= tli_pkg::CFG_RESET;
            error_count <= 0;
            results_checked <= 0;
            expected_values.delete();
        end else begin
            if (cfg_we) begin
                entries_cfg <= cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                if (expected_values.size() == 0) begin
                    $error("result_value: unexpected item %0d", $signed(m_tdata));
                    error_count <= error_count + 1;
                end else begin
                    if (m_tdata !== expected_values[0]) begin
                        $error("result_value: expected %0d, actual %0d",
                               $signed(expected_values[0]), $signed(m_tdata));
                        error_count <= error_count + 1;
                    end
                    void'(expected_values.pop_front());
                    results_checked <= results_checked + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    tli_pkg::OP_LOAD: begin
                        raw_tab[s_tdata[5:0]]   <= s_tdata[37:6];
                        score_tab[s_tdata[5:0]] <= s_tdata[69:38];
                    end
                    tli_pkg::OP_FWD:
                        expected_values = {expected_values,
                                           interpolate(1'b0, s_tdata[101:70])};
                    tli_pkg::OP_INV:
                        expected_values = {expected_values,
                                           interpolate(1'b1, s_tdata[101:70])};
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the table interpolator: directed loads and queries
// at the extremes, then phases of full table loads (sorted, duplicated keys,
// unordered, full range) each followed by queries under a phase's entry count.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [tli_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int MIN_V = 32'sh8000_0000;
    localparam int MAX_V = 32'sh7fff_ffff;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [6:0]   cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [31:0]  m_tdata;

    int  error_count, pending_results, results_checked;
    int  cycle_count = 0;
    bit  sender_idles = 1'b1;
    bit  receiver_idles = 1'b1;
    bit  hold_request = 1'b0;
    int  raw_keys [64];
    int  score_keys [64];
    int  entries_now = 1;
    int  queries_sent = 0;

    table_linear_interpolator DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    table_interp_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .error_count(error_count), .pending_results(pending_results),
        .results_checked(results_checked)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stall per item in idling phases, one long hold-off on request
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                stall = receiver_idles ? $urandom_range(0, 9) : 0;
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [5:0] idx,
                             input int raw, input int score, input int value);
        int gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= op;
        s_tdata  <= {2'b00, value, score, raw, idx};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (op == tli_pkg::OP_FWD || op == tli_pkg::OP_INV) queries_sent++;
    endtask

    task automatic load_pair(input int idx, input int raw, input int score);
        raw_keys[idx] = raw;
        score_keys[idx] = score;
        send_item(tli_pkg::OP_LOAD, idx[5:0], raw, score, $urandom);
    endtask

    task automatic set_entries(input logic [6:0] n);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wdata <= n;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        entries_now = (n == 0) ? 1 : ((n > 64) ? 64 : int'(n));
    endtask

    function automatic int pick_query(input bit inv);
        int i, a, b;
        i = $urandom_range(0, entries_now - 1);
        a = inv ? score_keys[i] : raw_keys[i];
        b = inv ? score_keys[entries_now - 1] : raw_keys[entries_now - 1];
        case ($urandom_range(0, 5))
            0: return a;
            1: return MIN_V;
            2: return MAX_V;
            3: return $urandom;
            default: return int'((longint'(a) + longint'(b)) / 2) + $urandom_range(0, 3) - 1;
        endcase
    endfunction

    task automatic load_table(input int kind);
        int raws[64], scores[64], pool[16];
        int i, order;
        for (i = 0; i < 16; i++) pool[i] = $urandom;
        for (i = 0; i < 64; i++) begin
            if (kind == 1) begin
                raws[i] = pool[$urandom_range(0, 15)];
                scores[i] = pool[$urandom_range(0, 15)];
            end else begin
                raws[i] = $urandom;
                scores[i] = $urandom;
            end
        end
        if (kind != 2) begin
            raws.sort();
            scores.sort();
        end
        if (kind == 3) begin
            raws[0] = MIN_V; raws[63] = MAX_V;
            scores[0] = MIN_V; scores[63] = MAX_V;
        end
        order = $urandom_range(0, 1);
        for (i = 0; i < 64; i++) begin
            if (order) load_pair(63 - i, raws[63 - i], scores[63 - i]);
            else load_pair(i, raws[i], scores[i]);
        end
    endtask

    initial begin
        logic [6:0] settings [8];
        int p, k;
        bit inv;
        settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd33, 7'd64, 7'd5};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one entry, then four, extremes of every field
        load_pair(0, MIN_V, MAX_V);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, MIN_V);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, MAX_V);
        send_item(tli_pkg::OP_INV, 6'd0, 0, 0, 0);
        send_item(OP_UNUSED, 6'h3f, MAX_V, MIN_V, -1);
        load_pair(1, -65536, 0);
        load_pair(2, 65536, 0);
        load_pair(3, MAX_V, MIN_V);
        load_pair(63, -1, -1);
        set_entries(7'd4);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, MIN_V);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, -65536);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, 12345);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, 65537);
        send_item(tli_pkg::OP_FWD, 6'd0, 0, 0, MAX_V);
        send_item(tli_pkg::OP_INV, 6'd0, 0, 0, MIN_V);
        send_item(tli_pkg::OP_INV, 6'd0, 0, 0, 0);
        send_item(tli_pkg::OP_INV, 6'd0, 0, 0, -7);
        send_item(tli_pkg::OP_INV, 6'd0, 0, 0, MAX_V);

        for (p = 0; p < 8; p++) begin
            sender_idles = (p % 3) != 1;
            receiver_idles = (p % 4) != 2;
            set_entries(7'd64);
            load_table(p % 4);
            set_entries(p == 5 ? 7'($urandom_range(2, 63)) : settings[p]);
            if (p == 1) hold_request = 1'b1;
            for (k = 0; k < 52; k++) begin
                inv = $urandom_range(0, 1);
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_UNUSED, 6'($urandom), $urandom, $urandom, $urandom);
                send_item(inv ? tli_pkg::OP_INV : tli_pkg::OP_FWD, 6'($urandom),
                          $urandom, $urandom, pick_query(inv));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d queries over sorted, duplicate-key, unordered and",
                 queries_sent);
        $display("full-range tables with entry counts 0 to 127; %0d results checked.",
                 results_checked);
        if (error_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
